// ===== design/mtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// match timer switch controller package
// payload types and button status codes
// ----------------------------------------------------------------------------
package mtsc_pkg;

    typedef struct packed {
        logic [15:0] tick_count;
        logic        drive_select;
        logic        auton_select;
        logic        start_pressed;
    } sample_t;

    typedef struct packed {
        logic [4:0] port_code;
        logic [2:0] button_status;
    } result_t;

    localparam logic [2:0] BTN_IDLE  = 3'd0;
    localparam logic [2:0] BTN_PRESS = 3'd1;
    localparam logic [2:0] BTN_LONG  = 3'd2;
    localparam logic [2:0] BTN_CLICK = 3'd3;
    localparam logic [2:0] BTN_EXTRA = 3'd4;

    localparam logic [4:0] PORT_INIT      = 5'h0F;
    localparam logic [4:0] PORT_DC        = 5'h0E;
    localparam logic [4:0] PORT_AUT_IDLE  = 5'h00;
    localparam logic [4:0] PORT_DRV_IDLE  = 5'h08;
    localparam logic [4:0] PORT_DRV_DELAY = 5'h18;
    localparam logic [4:0] PORT_AUT_RUN   = 5'h04;
    localparam logic [4:0] PORT_AUT_UNLIM = 5'h14;
    localparam logic [4:0] PORT_DRV_RUN   = 5'h0C;

    localparam logic [2:0] REG_SETTLE       = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
    localparam logic [2:0] REG_DRIVE_DELAY  = 3'd2;
    localparam logic [2:0] REG_MATCH_DRIVE  = 3'd3;
    localparam logic [2:0] REG_SKILLS_DRIVE = 3'd4;
    localparam logic [2:0] REG_MATCH_AUTON  = 3'd5;
    localparam logic [2:0] REG_SKILLS_AUTON = 3'd6;

endpackage

// ===== design/match_timer_switch_controller_core.sv =====
// ----------------------------------------------------------------------------
// match timer switch controller core
// button classifier and eight-state match mode machine; unless stalled, one sample per cycle
// ----------------------------------------------------------------------------
// Each request transaction carries one sample of the tick counter, the two
// selector lines and the start button, and yields exactly one response
// transaction with the port code and button status after the update. The
// block takes one sample every clock cycle unless stalled: all classifier and
// mode logic sits between the state registers and a single response register,
// and a new sample is accepted whenever the response register is empty or
// being emptied in the same cycle. The user must write the timing registers
// through the APB-style port only while idle; the block does not enforce it.
module match_timer_switch_controller_core
    import mtsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  sample_t     req_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output result_t     rsp_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        MODE_INIT  = 3'd0,
        MODE_DC    = 3'd1,
        MODE_D_AUT = 3'd2,
        MODE_D_DRV = 3'd3,
        MODE_T_DRV = 3'd4,
        MODE_R_AUT = 3'd5,
        MODE_I_AUT = 3'd6,
        MODE_R_DRV = 3'd7
    } mode_t;

    logic [7:0]  settle_reg;
    logic [15:0] long_press_reg;
    logic [14:0] drive_delay_reg;
    logic [14:0] match_drive_reg;
    logic [14:0] skills_drive_reg;
    logic [15:0] match_auton_reg;
    logic [15:0] skills_auton_reg;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [2:0]  button_reg;
    logic [2:0]  button_next;
    logic [15:0] button_base_reg;
    logic [15:0] button_base_next;
    logic [15:0] run_start_reg;
    logic [15:0] run_start_next;
    logic [15:0] run_length_reg;
    logic [15:0] run_length_next;

    logic        rsp_valid_reg;
    result_t     rsp_data_reg;
    result_t     rsp_data_next;

    logic        req_fire;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] btn_since;
    logic [15:0] run_since;
    logic [15:0] match_drive_len;
    logic [15:0] skills_drive_len;
    logic        run_expired;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    always_comb
    begin
        prdata = 32'd0;
        unique case (cfg_index)
            REG_SETTLE:       prdata = {24'd0, settle_reg};
            REG_LONG_PRESS:   prdata = {16'd0, long_press_reg};
            REG_DRIVE_DELAY:  prdata = {17'd0, drive_delay_reg};
            REG_MATCH_DRIVE:  prdata = {17'd0, match_drive_reg};
            REG_SKILLS_DRIVE: prdata = {17'd0, skills_drive_reg};
            REG_MATCH_AUTON:  prdata = {16'd0, match_auton_reg};
            REG_SKILLS_AUTON: prdata = {16'd0, skills_auton_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign btn_since        = req_data.tick_count - button_base_reg;
    assign run_since        = req_data.tick_count - run_start_reg;
    assign match_drive_len  = {1'b0, drive_delay_reg} + {1'b0, match_drive_reg};
    assign skills_drive_len = {1'b0, drive_delay_reg} + {1'b0, skills_drive_reg};
    assign run_expired      = (run_length_reg != 16'd0) && (run_since >= run_length_reg);

    // button classifier
    always_comb
    begin
        button_next      = button_reg;
        button_base_next = button_base_reg;
        if (btn_since < {8'd0, settle_reg})
        begin
            if (button_reg == BTN_CLICK || button_reg == BTN_EXTRA)
                button_next = BTN_IDLE;
        end
        else if (button_reg == BTN_IDLE && req_data.start_pressed)
        begin
            button_next      = BTN_PRESS;
            button_base_next = req_data.tick_count;
        end
        else if (button_reg == BTN_PRESS)
        begin
            if (req_data.start_pressed)
            begin
                if (btn_since > long_press_reg)
                    button_next = BTN_LONG;
            end
            else
            begin
                button_next      = BTN_CLICK;
                button_base_next = req_data.tick_count;
            end
        end
        else if (button_reg == BTN_LONG)
        begin
            if (!req_data.start_pressed)
            begin
                button_next      = BTN_EXTRA;
                button_base_next = req_data.tick_count;
            end
        end
        else
        begin
            button_next = BTN_IDLE;
        end
    end

    // mode machine
    always_comb
    begin
        logic drv;
        logic aut;
        logic click;
        logic extra;
        drv             = req_data.drive_select;
        aut             = req_data.auton_select;
        click           = (button_next == BTN_CLICK);
        extra           = (button_next == BTN_EXTRA);
        mode_next       = mode_reg;
        run_start_next  = run_start_reg;
        run_length_next = run_length_reg;
        unique case (mode_reg)
            MODE_INIT:
                mode_next = drv ? MODE_D_DRV : (aut ? MODE_D_AUT : MODE_DC);
            MODE_DC:
            begin
                if (drv)
                    mode_next = MODE_D_DRV;
                else if (aut)
                    mode_next = MODE_D_AUT;
                else if (extra)
                    mode_next = MODE_I_AUT;
            end
            MODE_D_DRV:
            begin
                if (!drv)
                    mode_next = aut ? MODE_D_AUT : MODE_DC;
                else if (click || extra)
                begin
                    mode_next       = MODE_T_DRV;
                    run_start_next  = req_data.tick_count;
                    run_length_next = click ? match_drive_len : skills_drive_len;
                end
            end
            MODE_T_DRV:
            begin
                if (!drv)
                    mode_next = aut ? MODE_D_AUT : MODE_DC;
                else if (run_since > {1'b0, drive_delay_reg})
                    mode_next = MODE_R_DRV;
                else if (click)
                    mode_next = MODE_D_DRV;
            end
            MODE_D_AUT:
            begin
                if (!aut)
                    mode_next = drv ? MODE_D_DRV : MODE_DC;
                else if (click || extra)
                begin
                    mode_next       = MODE_R_AUT;
                    run_start_next  = req_data.tick_count;
                    run_length_next = click ? match_auton_reg : skills_auton_reg;
                end
            end
            MODE_R_AUT:
            begin
                if (!aut)
                    mode_next = drv ? MODE_D_DRV : MODE_DC;
                else
                begin
                    if (run_expired)
                        run_length_next = 16'd0;
                    if (run_expired || run_length_reg == 16'd0 || click)
                        mode_next = MODE_D_AUT;
                end
            end
            MODE_I_AUT:
            begin
                if (drv)
                    mode_next = MODE_D_DRV;
                else if (aut)
                    mode_next = MODE_D_AUT;
                else if (click)
                    mode_next = MODE_DC;
            end
            MODE_R_DRV:
            begin
                if (!drv)
                    mode_next = aut ? MODE_D_AUT : MODE_DC;
                else
                begin
                    if (run_expired)
                        run_length_next = 16'd0;
                    if (run_expired || run_length_reg == 16'd0 || click)
                        mode_next = MODE_D_DRV;
                end
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    always_comb
    begin
        rsp_data_next.button_status = button_next;
        unique case (mode_next)
            MODE_INIT:  rsp_data_next.port_code = PORT_INIT;
            MODE_DC:    rsp_data_next.port_code = PORT_DC;
            MODE_D_AUT: rsp_data_next.port_code = PORT_AUT_IDLE;
            MODE_D_DRV: rsp_data_next.port_code = PORT_DRV_IDLE;
            MODE_T_DRV: rsp_data_next.port_code = PORT_DRV_DELAY;
            MODE_R_AUT: rsp_data_next.port_code = PORT_AUT_RUN;
            MODE_I_AUT: rsp_data_next.port_code = PORT_AUT_UNLIM;
            MODE_R_DRV: rsp_data_next.port_code = PORT_DRV_RUN;
            default:    rsp_data_next.port_code = PORT_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg       <= 8'd6;
            long_press_reg   <= 16'd64;
            drive_delay_reg  <= 15'd192;
            match_drive_reg  <= 15'd13440;
            skills_drive_reg <= 15'd7680;
            match_auton_reg  <= 16'd1920;
            skills_auton_reg <= 16'd7680;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SETTLE:       settle_reg       <= pwdata[7:0];
                REG_LONG_PRESS:   long_press_reg   <= pwdata[15:0];
                REG_DRIVE_DELAY:  drive_delay_reg  <= pwdata[14:0];
                REG_MATCH_DRIVE:  match_drive_reg  <= pwdata[14:0];
                REG_SKILLS_DRIVE: skills_drive_reg <= pwdata[14:0];
                REG_MATCH_AUTON:  match_auton_reg  <= pwdata[15:0];
                REG_SKILLS_AUTON: skills_auton_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_INIT;
            button_reg      <= BTN_IDLE;
            button_base_reg <= 16'd0;
            run_start_reg   <= 16'd0;
            run_length_reg  <= 16'd0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                mode_reg        <= mode_next;
                button_reg      <= button_next;
                button_base_reg <= button_base_next;
                run_start_reg   <= run_start_next;
                run_length_reg  <= run_length_next;
                rsp_valid_reg   <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            rsp_data_reg <= rsp_data_next;
    end

`ifndef SYNTHESIS
    // every accepted transaction produces a response in the next cycle
    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> rsp_valid_reg)
        else $error("accepted sample without response");

    // init state is left on the first sample
    a_init_left: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> mode_reg != MODE_INIT)
        else $error("mode machine stuck in init");

    // click and long release events last one step
    a_event_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (button_reg == BTN_CLICK || button_reg == BTN_EXTRA)
        |=> button_reg == BTN_IDLE)
        else $error("button event held past one step");

    // an empty response register never stalls the request side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid_reg |-> req_ready)
        else $error("request stalled with empty response register");
`endif

endmodule

// ===== sim/match_timer_switch_controller_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match timer switch controller core testbench
// ----------------------------------------------------------------------------
// Drives tick counter, selector and start button samples into the core and
// predicts each response transaction with an in-bench model of the button
// classifier and the mode machine. Timing registers are loaded over the
// APB-style port between phases: reset values, small, all zero, all maximum
// and random settings. Stimulus is built from press, hold, release, wait and
// selector episodes with bounces, tick jumps and fully random samples mixed
// in. The sender runs in random bursts and the receiver stalls on a pattern.
// ----------------------------------------------------------------------------
module match_timer_switch_controller_core_tb;
    import mtsc_pkg::*;

    typedef enum logic [2:0] {
        MODE_INIT,
        MODE_DC,
        MODE_AUT_IDLE,
        MODE_DRV_IDLE,
        MODE_DRV_DELAY,
        MODE_AUT_RUN,
        MODE_AUT_UNLIM,
        MODE_DRV_RUN
    } ctl_mode_t;

    localparam logic [2:0] REG_SPARE = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    sample_t     req_data = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    result_t     rsp_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // timing registers as the core should hold them
    logic [7:0]  cfg_settle = 8'd6;
    logic [15:0] cfg_long = 16'd64;
    logic [14:0] cfg_delay = 15'd192;
    logic [14:0] cfg_match_drv = 15'd13440;
    logic [14:0] cfg_skills_drv = 15'd7680;
    logic [15:0] cfg_match_aut = 16'd1920;
    logic [15:0] cfg_skills_aut = 16'd7680;

    // controller state
    ctl_mode_t   ctl_mode = MODE_INIT;
    logic [2:0]  btn_state = BTN_IDLE;
    logic [15:0] btn_base = '0;
    logic [15:0] run_start = '0;
    logic [15:0] run_len = '0;

    sample_t     pending_samples[$];
    result_t     expected_results[$];
    result_t     rsp_expected;
    int unsigned samples_queued = 0;
    int unsigned error_count = 0;

    logic [15:0] tick_now = '0;
    logic        sel_drv = 1'b0;
    logic        sel_aut = 1'b0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic [31:0] ready_mask = '1;
    logic [31:0] rx_cycle = '0;

    match_timer_switch_controller_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] ticks_since(logic [15:0] now, logic [15:0] mark);
        return now - mark;
    endfunction

    function automatic bit run_still_live(logic [15:0] now);
        if (run_len != 0 && ticks_since(now, run_start) >= run_len)
            run_len = '0;
        return run_len != 0;
    endfunction

    function automatic logic [4:0] port_of(ctl_mode_t m);
        case (m)
            MODE_INIT:      return PORT_INIT;
            MODE_DC:        return PORT_DC;
            MODE_AUT_IDLE:  return PORT_AUT_IDLE;
            MODE_DRV_IDLE:  return PORT_DRV_IDLE;
            MODE_DRV_DELAY: return PORT_DRV_DELAY;
            MODE_AUT_RUN:   return PORT_AUT_RUN;
            MODE_AUT_UNLIM: return PORT_AUT_UNLIM;
            default:        return PORT_DRV_RUN;
        endcase
    endfunction

    function automatic result_t next_port_and_status(sample_t s);
        logic [15:0] now;
        logic        drv;
        logic        aut;
        logic        btn;
        logic [2:0]  ev;
        result_t     r;
        now = s.tick_count;
        drv = s.drive_select;
        aut = s.auton_select;
        btn = s.start_pressed;

        // button classifier
        if (ticks_since(now, btn_base) < {8'd0, cfg_settle})
        begin
            if (btn_state == BTN_CLICK || btn_state == BTN_EXTRA)
                btn_state = BTN_IDLE;
        end
        else if (btn_state == BTN_IDLE && btn)
        begin
            btn_base = now;
            btn_state = BTN_PRESS;
        end
        else if (btn_state == BTN_PRESS)
        begin
            if (btn)
            begin
                if (ticks_since(now, btn_base) > cfg_long)
                    btn_state = BTN_LONG;
            end
            else
            begin
                btn_state = BTN_CLICK;
                btn_base = now;
            end
        end
        else if (btn_state == BTN_LONG)
        begin
            if (!btn)
            begin
                btn_state = BTN_EXTRA;
                btn_base = now;
            end
        end
        else
            btn_state = BTN_IDLE;
        ev = btn_state;

        // mode machine
        case (ctl_mode)
            MODE_INIT:
                ctl_mode = drv ? MODE_DRV_IDLE : (aut ? MODE_AUT_IDLE : MODE_DC);
            MODE_DC:
                if (drv)
                    ctl_mode = MODE_DRV_IDLE;
                else if (aut)
                    ctl_mode = MODE_AUT_IDLE;
                else if (ev == BTN_EXTRA)
                    ctl_mode = MODE_AUT_UNLIM;
            MODE_DRV_IDLE:
                if (!drv)
                    ctl_mode = aut ? MODE_AUT_IDLE : MODE_DC;
                else if (ev == BTN_CLICK || ev == BTN_EXTRA)
                begin
                    run_start = now;
                    run_len = {1'b0, cfg_delay} +
                              {1'b0, (ev == BTN_CLICK) ? cfg_match_drv : cfg_skills_drv};
                    ctl_mode = MODE_DRV_DELAY;
                end
            MODE_DRV_DELAY:
                if (!drv)
                    ctl_mode = aut ? MODE_AUT_IDLE : MODE_DC;
                else
                begin
                    if (ev == BTN_CLICK)
                        ctl_mode = MODE_DRV_IDLE;
                    if (ticks_since(now, run_start) > {1'b0, cfg_delay})
                        ctl_mode = MODE_DRV_RUN;
                end
            MODE_AUT_IDLE:
                if (!aut)
                    ctl_mode = drv ? MODE_DRV_IDLE : MODE_DC;
                else if (ev == BTN_CLICK || ev == BTN_EXTRA)
                begin
                    run_start = now;
                    run_len = (ev == BTN_CLICK) ? cfg_match_aut : cfg_skills_aut;
                    ctl_mode = MODE_AUT_RUN;
                end
            MODE_AUT_RUN:
                if (!aut)
                    ctl_mode = drv ? MODE_DRV_IDLE : MODE_DC;
                else if (!run_still_live(now) || ev == BTN_CLICK)
                    ctl_mode = MODE_AUT_IDLE;
            MODE_AUT_UNLIM:
                if (drv)
                    ctl_mode = MODE_DRV_IDLE;
                else if (aut)
                    ctl_mode = MODE_AUT_IDLE;
                else if (ev == BTN_CLICK)
                    ctl_mode = MODE_DC;
            default:
                if (!drv)
                    ctl_mode = aut ? MODE_AUT_IDLE : MODE_DC;
                else if (!run_still_live(now) || ev == BTN_CLICK)
                    ctl_mode = MODE_DRV_IDLE;
        endcase

        r.port_code = port_of(ctl_mode);
        r.button_status = ev;
        return r;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_SETTLE:       cfg_settle = val[7:0];
            REG_LONG_PRESS:   cfg_long = val[15:0];
            REG_DRIVE_DELAY:  cfg_delay = val[14:0];
            REG_MATCH_DRIVE:  cfg_match_drv = val[14:0];
            REG_SKILLS_DRIVE: cfg_skills_drv = val[14:0];
            REG_MATCH_AUTON:  cfg_match_aut = val[15:0];
            REG_SKILLS_AUTON: cfg_skills_aut = val[15:0];
            default: ;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        apply_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_timing(int unsigned s, int unsigned l, int unsigned d,
                               int unsigned md, int unsigned sd,
                               int unsigned ma, int unsigned sa, bit junk);
        write_reg(REG_SETTLE, s | (junk ? ($urandom << 8) : 0));
        write_reg(REG_LONG_PRESS, l | (junk ? ($urandom << 16) : 0));
        write_reg(REG_DRIVE_DELAY, d | (junk ? ($urandom << 15) : 0));
        write_reg(REG_MATCH_DRIVE, md | (junk ? ($urandom << 15) : 0));
        write_reg(REG_SKILLS_DRIVE, sd | (junk ? ($urandom << 15) : 0));
        write_reg(REG_MATCH_AUTON, ma | (junk ? ($urandom << 16) : 0));
        write_reg(REG_SKILLS_AUTON, sa | (junk ? ($urandom << 16) : 0));
        write_reg(REG_SPARE, $urandom);
    endtask

    task automatic wait_idle();
        while (pending_samples.size() != 0 || expected_results.size() != 0 || req_valid)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic add_sample(bit btn);
        sample_t s;
        s.tick_count = tick_now;
        s.drive_select = sel_drv;
        s.auton_select = sel_aut;
        s.start_pressed = btn;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    task automatic put_sample(logic [15:0] t, bit drv, bit aut, bit btn);
        tick_now = t;
        sel_drv = drv;
        sel_aut = aut;
        add_sample(btn);
    endtask

    // holds the button level for at least span ticks, in samples at random steps
    task automatic hold_button(bit btn, int unsigned span);
        int unsigned done;
        int unsigned stride;
        int unsigned d;
        done = 0;
        stride = span / $urandom_range(2, 6) + 1;
        do
        begin
            d = $urandom_range(0, stride);
            done += d;
            tick_now += 16'(d);
            add_sample(btn);
        end
        while (done < span);
    endtask

    task automatic queue_episodes(int unsigned n);
        int unsigned target;
        int unsigned run_span;
        int unsigned top_len;
        sample_t     s;
        target = samples_queued + n;
        while (samples_queued < target)
        begin
            top_len = cfg_match_drv;
            if (cfg_skills_drv > top_len) top_len = cfg_skills_drv;
            if (cfg_match_aut > top_len) top_len = cfg_match_aut;
            if (cfg_skills_aut > top_len) top_len = cfg_skills_aut;
            run_span = cfg_delay + top_len + 2;
            case ($urandom_range(0, 11))
                0, 1:
                begin
                    {sel_drv, sel_aut} = 2'($urandom_range(0, 3));
                    add_sample(1'b0);
                end
                2, 3, 4:
                begin
                    hold_button(1'b1, $urandom_range(cfg_settle, cfg_long));
                    hold_button(1'b0, cfg_settle + $urandom_range(0, 4));
                end
                5, 6:
                begin
                    hold_button(1'b1, cfg_long + $urandom_range(1, cfg_settle + 8));
                    hold_button(1'b0, cfg_settle + $urandom_range(0, 4));
                end
                7, 8:
                    hold_button(1'b0, $urandom_range(0, run_span));
                9:
                    repeat ($urandom_range(1, 4))
                    begin
                        s = sample_t'(19'($urandom));
                        tick_now = s.tick_count;
                        pending_samples.push_back(s);
                        samples_queued++;
                    end
                10:
                    repeat ($urandom_range(2, 6))
                    begin
                        tick_now += 16'($urandom_range(0, cfg_settle / 2 + 1));
                        add_sample(1'($urandom_range(0, 1)));
                    end
                default:
                begin
                    tick_now += 16'($urandom_range(0, 65535));
                    add_sample(1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    // sender: bursts of transactions with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_results.push_back(next_port_and_status(req_data));
            if (!req_valid || req_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    req_data <= pending_samples.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern refreshed when the low six bits of rx_cycle are zero
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, rsp_data);
                    error_count++;
                end
                else
                begin
                    rsp_expected = expected_results.pop_front();
                    if (rsp_data.port_code !== rsp_expected.port_code)
                    begin
                        $display("%0t: port_code expected %0d actual %0d",
                                 $time, rsp_expected.port_code, rsp_data.port_code);
                        error_count++;
                    end
                    if (rsp_data.button_status !== rsp_expected.button_status)
                    begin
                        $display("%0t: button_status expected %0d actual %0d",
                                 $time, rsp_expected.button_status, rsp_data.button_status);
                        error_count++;
                    end
                end
            end
            if (rx_cycle[5:0] == 6'd0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_mask <= '1;
                    1: ready_mask <= $urandom | $urandom;
                    2: ready_mask <= $urandom;
                    default: ready_mask <= $urandom & $urandom;
                endcase
            end
            rsp_ready <= ready_mask[rx_cycle[4:0]];
            rx_cycle <= rx_cycle + 1;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed sequence under reset timing
        put_sample(16'd0, 0, 0, 0);
        put_sample(16'hFFFF, 1, 1, 1);
        put_sample(16'd3, 1, 0, 0);
        put_sample(16'd10, 1, 0, 0);
        put_sample(16'd100, 1, 0, 0);
        put_sample(16'd203, 1, 0, 0);
        put_sample(16'd300, 1, 0, 1);
        put_sample(16'd310, 1, 0, 0);
        put_sample(16'd400, 1, 0, 1);
        put_sample(16'd470, 1, 0, 1);
        put_sample(16'd480, 1, 0, 0);
        put_sample(16'd490, 0, 1, 0);
        put_sample(16'd600, 0, 1, 1);
        put_sample(16'd610, 0, 1, 0);
        put_sample(16'd2530, 0, 1, 0);
        put_sample(16'd2600, 0, 0, 1);
        put_sample(16'd2700, 0, 0, 1);
        put_sample(16'd2710, 0, 0, 0);
        put_sample(16'd2800, 0, 0, 1);
        put_sample(16'd2810, 0, 0, 0);
        put_sample(16'hFFF0, 0, 1, 0);
        put_sample(16'hFFFF, 1, 1, 1);
        wait_idle();

        load_timing(2, 10, 6, 20, 45, 12, 30, 1'b0);
        queue_episodes(220);
        wait_idle();

        load_timing(0, 0, 0, 0, 0, 0, 0, 1'b0);
        queue_episodes(110);
        wait_idle();

        load_timing(255, 65535, 32767, 32767, 32767, 65535, 65535, 1'b0);
        queue_episodes(110);
        wait_idle();

        repeat (2)
        begin
            load_timing($urandom_range(0, 40), $urandom_range(0, 200), $urandom_range(0, 300),
                        $urandom_range(0, 600), $urandom_range(0, 600),
                        $urandom_range(0, 600), $urandom_range(0, 1000), 1'b1);
            queue_episodes(180);
            wait_idle();
        end

        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
